// File: sv/fgmw_pkg.sv
// shared types and constants for the functional graph max walk sum block
`default_nettype none

package fgmw_pkg;

   // table geometry
   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 40;

   // fixed field widths
   localparam int RECV_W  = 10;
   localparam int STEP_W  = 40;
   localparam int SCORE_W = 50;

   // derived widths
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DEPTH   = LEVELS * MAX_NODES;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = RECV_W + SCORE_W;

   // one jump table entry: 2^j-step target and the path sum on the way
   typedef struct packed {
      logic [RECV_W-1:0]  target;
      logic [SCORE_W-1:0] sum;
   } jump_entry_type;

   // sequencer states
   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_BLD_A = 6'b000010,
      ST_BLD_B = 6'b000100,
      ST_BLD_C = 6'b001000,
      ST_QRY_L = 6'b010000,
      ST_QRY_W = 6'b100000
   } state_type;

   // flat table address of a level and a node
   function automatic logic [ADDR_W-1:0] jump_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [NODE_W-1:0] node);
      logic [ADDR_W+LVL_W-1:0] base;
      base = (ADDR_W+LVL_W)'(lvl) * (ADDR_W+LVL_W)'(MAX_NODES);
      return ADDR_W'(base) + ADDR_W'(node);
   endfunction

endpackage

`default_nettype wire

// File: sv/fgmw_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fgmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/functional_graph_max_walk_sum_top.sv
// functional graph max walk sum: table load, jump table build and walk query
//
// Usage:
//   csr_ channel writes step_count (number of passes k); write only while idle.
//   req_ channel loads the successor table one entry per beat, in node order;
//   req_last_entry closes the table and starts the computation. Entries past
//   MAX_NODES are dropped and flag the table as bad.
//   rsp_ channel returns one beat per table: best_score and bad_input.
// Sequence:
//   after the last entry the build composes levels 1 to LEVELS - 1 for every
//   node, with three table accesses per node and level (two reads, one write);
//   the query then walks every start node down the levels, with one table read
//   for each set bit of step_count below LEVELS. The result then moves to the
//   output register. A bad table skips both phases.
//   req_ready stays low from the last entry until the result is registered.
// Reset: step_count returns to 1, the load count clears and no result is held.
//   The jump table needs no clearing pass: every entry is written before read.
// Stall: a held result waits in the output register; a finished computation
//   waits for that register to free up before loading is resumed.
`default_nettype none

module functional_graph_max_walk_sum_top
   import fgmw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [STEP_W-1:0]  csr_step_count,
   // table entries
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [RECV_W-1:0]  req_receiver,
   input  wire logic               req_last_entry,
   // results
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [SCORE_W-1:0]      rsp_best_score,
   output logic                    rsp_bad_input
);

   // control registers
   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_count_ff, step_count_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [RECV_W-1:0]   max_recv_ff, max_recv_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                done_ff, done_in;

   // datapath registers
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_W-1:0]   idx_ff, idx_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [SCORE_W-1:0]  total_ff, total_in;
   logic [SCORE_W-1:0]  hold_sum_ff, hold_sum_in;
   logic [SCORE_W-1:0]  best_ff, best_in;
   logic                bad_ff, bad_in;
   logic [SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic                rsp_bad_ff, rsp_bad_in;

   // table port signals
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   jump_entry_type      wr_entry;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   jump_entry_type      rd_entry;

   // helpers
   logic                load_beat;
   logic [CNT_W-1:0]    n_new;
   logic [RECV_W-1:0]   max_new;
   logic                ovf_new;
   logic [NODE_W-1:0]   last_idx;
   logic                step_bit;
   logic                adv_go;
   logic [SCORE_W-1:0]  adv_total;
   logic                out_free;

   // jump table: level-major, one entry per node and level
   fgmw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_jump_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == ST_LOAD) && !done_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_score = rsp_score_ff;
   assign rsp_bad_input  = rsp_bad_ff;

   assign load_beat = req_valid && req_ready;
   assign last_idx  = NODE_W'(n_ff - CNT_W'(1));
   assign step_bit  = step_count_ff[lvl_ff];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // per-entry load bookkeeping
   always_comb begin
      n_new   = count_ff;
      max_new = max_recv_ff;
      ovf_new = ovf_ff;
      if (count_ff < CNT_W'(MAX_NODES)) begin
         n_new   = count_ff + CNT_W'(1);
         max_new = (req_receiver > max_recv_ff) ? req_receiver : max_recv_ff;
      end else begin
         ovf_new = 1'b1;
      end
   end

   // query step advance: a clear bit advances directly, a set bit adds a read first
   assign adv_go    = ((state_ff == ST_QRY_L) && !step_bit) || (state_ff == ST_QRY_W);
   assign adv_total = (state_ff == ST_QRY_W) ? (total_ff + rd_entry.sum) : total_ff;

   // sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      step_count_in = step_count_ff;
      count_in      = count_ff;
      max_recv_in   = max_recv_ff;
      ovf_in        = ovf_ff;
      done_in       = done_ff;
      n_in          = n_ff;
      lvl_in        = lvl_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      total_in      = total_ff;
      hold_sum_in   = hold_sum_ff;
      best_in       = best_ff;
      bad_in        = bad_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      wr_en    = 1'b0;
      wr_addr  = jump_addr(LVL_W'(0), NODE_W'(count_ff));
      wr_entry = '{target: req_receiver, sum: SCORE_W'(req_receiver)};
      rd_en    = 1'b0;
      rd_addr  = jump_addr(lvl_ff, idx_ff);

      if (csr_valid) begin
         step_count_in = csr_step_count;
      end

      case (state_ff)
         ST_LOAD: begin
            // hand a finished result to the output register
            if (done_ff && out_free) begin
               done_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_score_in = best_ff;
               rsp_bad_in   = bad_ff;
            end
            // store level zero directly from the entry
            if (load_beat) begin
               wr_en       = !ovf_new;
               count_in    = n_new;
               max_recv_in = max_new;
               ovf_in      = ovf_new;
               if (req_last_entry) begin
                  n_in        = n_new;
                  count_in    = '0;
                  max_recv_in = '0;
                  ovf_in      = 1'b0;
                  idx_in      = '0;
                  best_in     = '0;
                  if (ovf_new || (CNT_W'(max_new) >= n_new)) begin
                     bad_in  = 1'b1;
                     done_in = 1'b1;
                  end else if (LEVELS > 1) begin
                     bad_in   = 1'b0;
                     lvl_in   = LVL_W'(1);
                     state_in = ST_BLD_A;
                  end else begin
                     bad_in   = 1'b0;
                     lvl_in   = LVL_W'(LEVELS - 1);
                     node_in  = '0;
                     total_in = '0;
                     state_in = ST_QRY_L;
                  end
               end
            end
         end
         ST_BLD_A: begin
            // read the previous level at this node
            rd_en    = 1'b1;
            rd_addr  = jump_addr(lvl_ff - LVL_W'(1), idx_ff);
            state_in = ST_BLD_B;
         end
         ST_BLD_B: begin
            // follow the half-way target on the previous level
            rd_en       = 1'b1;
            rd_addr     = jump_addr(lvl_ff - LVL_W'(1), NODE_W'(rd_entry.target));
            hold_sum_in = rd_entry.sum;
            state_in    = ST_BLD_C;
         end
         ST_BLD_C: begin
            // compose two half jumps into this level
            wr_en    = 1'b1;
            wr_addr  = jump_addr(lvl_ff, idx_ff);
            wr_entry = '{target: rd_entry.target, sum: hold_sum_ff + rd_entry.sum};
            state_in = ST_BLD_A;
            if (idx_ff == last_idx) begin
               idx_in = '0;
               if (lvl_ff == LVL_W'(LEVELS - 1)) begin
                  node_in  = '0;
                  total_in = '0;
                  state_in = ST_QRY_L;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end else begin
               idx_in = idx_ff + NODE_W'(1);
            end
         end
         ST_QRY_L: begin
            // look up the jump for a set count bit
            if (step_bit) begin
               rd_en    = 1'b1;
               rd_addr  = jump_addr(lvl_ff, node_ff);
               state_in = ST_QRY_W;
            end
         end
         ST_QRY_W: begin
            node_in  = NODE_W'(rd_entry.target);
            state_in = ST_QRY_L;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // walk bookkeeping shared by both query states
      if (adv_go) begin
         total_in = adv_total;
         if (lvl_ff == '0) begin
            best_in = (adv_total > best_ff) ? adv_total : best_ff;
            lvl_in  = LVL_W'(LEVELS - 1);
            if (idx_ff == last_idx) begin
               done_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               idx_in   = idx_ff + NODE_W'(1);
               node_in  = idx_ff + NODE_W'(1);
               total_in = SCORE_W'(idx_ff) + SCORE_W'(1);
               state_in = ST_QRY_L;
            end
         end else begin
            lvl_in = lvl_ff - LVL_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         step_count_ff <= STEP_W'(1);
         count_ff      <= '0;
         max_recv_ff   <= '0;
         ovf_ff        <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_count_ff <= step_count_in;
         count_ff      <= count_in;
         max_recv_ff   <= max_recv_in;
         ovf_ff        <= ovf_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      lvl_ff       <= lvl_in;
      idx_ff       <= idx_in;
      node_ff      <= node_in;
      total_ff     <= total_in;
      hold_sum_ff  <= hold_sum_in;
      best_ff      <= best_in;
      bad_ff       <= bad_in;
      rsp_score_ff <= rsp_score_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // a rejected table never reports a score
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_score_ff == '0)
      else $error("bad table reported a nonzero score");

   // the table is written only while loading or composing a level
   a_wr_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_LOAD) || (state_ff == ST_BLD_C))
      else $error("jump table written outside load or build");

   // the walk never leaves the loaded nodes
   a_node_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_L) |-> (CNT_W'(node_ff) < n_ff) && (CNT_W'(idx_ff) < n_ff))
      else $error("walk node outside loaded table");

   // a pending result blocks further loading
   a_no_load_pending: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !req_ready)
      else $error("entry accepted while a result is pending");

endmodule

`default_nettype wire
